// File: rtl/polygon_point_containment_unit_assert.svh
// Assertion macros for the polygon point containment unit.
`ifndef POLYGON_POINT_CONTAINMENT_UNIT_ASSERT_SVH
`define POLYGON_POINT_CONTAINMENT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define PPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppc assertion failed");
// Next-cycle implication, checked out of reset.
`define PPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppc assertion failed");
`else
`define PPC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PPC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/ppc_pkg.sv
// Shared types and constants for the polygon point containment unit.
package ppc_pkg;

    localparam int COORD_W          = 16;
    localparam int DIFF_W           = COORD_W + 1;
    localparam int PROD_W           = 2 * DIFF_W;
    localparam int CNT_W            = 5;
    localparam int IDX_W            = 4;
    localparam int MAX_VERTICES_DEF = 16;
    localparam int IN_DATA_W        = 40;
    localparam int OUT_DATA_W       = 8;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vertex;

    // per-cell control
    typedef struct packed {
        logic wr;
        logic shift;
        logic wrap;
    } t_cell_ctl;

    // sequencer -> edge unit
    typedef struct packed {
        logic clear;
        logic issue;
    } t_edge_ctl;

    // edge unit -> sequencer
    typedef struct packed {
        logic busy;
        logic parity;
        logic hit;
    } t_edge_sts;

endpackage

// File: rtl/ppc_cell.sv
// One vertex cell of the rotating vertex ring.
module ppc_cell (
    input  logic               i_clk,
    input  ppc_pkg::t_cell_ctl i_ctl,
    input  ppc_pkg::t_vertex   i_wr_vtx,
    input  ppc_pkg::t_vertex   i_next,
    input  ppc_pkg::t_vertex   i_first,
    output ppc_pkg::t_vertex   o_vtx
);

    ppc_pkg::t_vertex r_vtx;

    // load wins; rotate takes the neighbor, or cell 0 at the ring's end
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_vtx <= i_wr_vtx;
        end else if (i_ctl.shift) begin
            r_vtx <= i_ctl.wrap ? i_first : i_next;
        end
    end

    assign o_vtx = r_vtx;

endmodule

// File: rtl/ppc_edge.sv
// Three-stage edge crossing test with parity and vertex-hit accumulation.
module ppc_edge (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ppc_pkg::t_edge_ctl                    i_ctl,
    input  ppc_pkg::t_vertex                      i_head,
    input  ppc_pkg::t_vertex                      i_prev,
    input  logic signed [ppc_pkg::COORD_W-1:0]    i_px,
    input  logic signed [ppc_pkg::COORD_W-1:0]    i_py,
    output ppc_pkg::t_edge_sts                    o_sts
);

    localparam int DW = ppc_pkg::DIFF_W;
    localparam int PW = ppc_pkg::PROD_W;

    // stage 1: differences
    logic                 r_s1_vld;
    logic                 r_s1_hit;
    logic                 r_s1_str;
    logic signed [DW-1:0] r_s1_dxp;
    logic signed [DW-1:0] r_s1_dy;
    logic signed [DW-1:0] r_s1_dxe;
    logic signed [DW-1:0] r_s1_dyp;

    // stage 2: products
    logic                 r_s2_vld;
    logic                 r_s2_hit;
    logic                 r_s2_str;
    logic                 r_s2_dypos;
    logic signed [PW-1:0] r_s2_lhs;
    logic signed [PW-1:0] r_s2_rhs;

    // stage 3: accumulators
    logic r_parity;
    logic r_hit;

    logic signed [DW-1:0] n_dxp;
    logic signed [DW-1:0] n_dy;
    logic signed [DW-1:0] n_dxe;
    logic signed [DW-1:0] n_dyp;
    logic                 n_str;
    logic                 n_hit;
    logic signed [PW-1:0] n_lhs;
    logic signed [PW-1:0] n_rhs;
    logic                 n_right;

    always_comb begin
        n_dxp = $signed({i_px[ppc_pkg::COORD_W-1], i_px})
              - $signed({i_head.x[ppc_pkg::COORD_W-1], i_head.x});
        n_dy  = $signed({i_prev.y[ppc_pkg::COORD_W-1], i_prev.y})
              - $signed({i_head.y[ppc_pkg::COORD_W-1], i_head.y});
        n_dxe = $signed({i_prev.x[ppc_pkg::COORD_W-1], i_prev.x})
              - $signed({i_head.x[ppc_pkg::COORD_W-1], i_head.x});
        n_dyp = $signed({i_py[ppc_pkg::COORD_W-1], i_py})
              - $signed({i_head.y[ppc_pkg::COORD_W-1], i_head.y});
        n_str = (i_head.y > i_py) != (i_prev.y > i_py);
        n_hit = (i_px == i_head.x) && (i_py == i_head.y);
        n_lhs = r_s1_dxp * r_s1_dy;
        n_rhs = r_s1_dxe * r_s1_dyp;
        // compare direction follows the sign of the edge's y span
        n_right = r_s2_dypos ? (r_s2_lhs < r_s2_rhs) : (r_s2_lhs > r_s2_rhs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_parity <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_s1_vld <= i_ctl.issue;
            r_s2_vld <= r_s1_vld;
            if (i_ctl.clear) begin
                r_parity <= 1'b0;
                r_hit    <= 1'b0;
            end else if (r_s2_vld) begin
                r_parity <= r_parity ^ (r_s2_str & n_right);
                r_hit    <= r_hit | r_s2_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_hit   <= n_hit;
        r_s1_str   <= n_str;
        r_s1_dxp   <= n_dxp;
        r_s1_dy    <= n_dy;
        r_s1_dxe   <= n_dxe;
        r_s1_dyp   <= n_dyp;
        r_s2_hit   <= r_s1_hit;
        r_s2_str   <= r_s1_str;
        r_s2_dypos <= !r_s1_dy[DW-1] && (r_s1_dy != '0);
        r_s2_lhs   <= n_lhs;
        r_s2_rhs   <= n_rhs;
    end

    assign o_sts.busy   = r_s1_vld | r_s2_vld;
    assign o_sts.parity = r_parity;
    assign o_sts.hit    = r_hit;

endmodule

// File: rtl/polygon_point_containment_unit.sv
// Polygon point containment unit: vertex ring, edge test pipeline and sequencer.
// A load beat writes its cell as it is taken; a query result is registered once the
// ring of vertex cells, rotating one vertex past the edge unit per cycle, has turned
// and the edge pipeline has drained, n being the vertex count in use (clamped to
// MAX_VERTICES); n = 0 skips the ring. No beat is taken until the result is loaded.
// Reset (synchronous, active low) clears control, the count and the output; vertex
// cells are not cleared and must be written before they are queried.
`include "polygon_point_containment_unit_assert.svh"

module polygon_point_containment_unit #(
    parameter int MAX_VERTICES = ppc_pkg::MAX_VERTICES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config: vertex_count
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ppc_pkg::CNT_W-1:0]       i_cfg_data,     // [4:0] vertex_count
    // item stream in
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [ppc_pkg::IN_DATA_W-1:0]   i_s_axis_tdata, // [3:0] vertex_index,
                                                            // [19:4] point_x,
                                                            // [35:20] point_y, rest 0
    input  logic                            i_s_axis_tuser, // [0] opcode
    // result stream out
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [ppc_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata  // [0] inside_res,
                                                            // [1] on_vertex, rest 0
);

    localparam int CW = ppc_pkg::CNT_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                          r_state;
    logic [1:0]                          n_state;
    logic [CW-1:0]                       r_cnt;
    logic [CW-1:0]                       r_step;
    logic [CW-1:0]                       n_step;
    logic signed [ppc_pkg::COORD_W-1:0]  r_px;
    logic signed [ppc_pkg::COORD_W-1:0]  r_py;
    ppc_pkg::t_vertex                    r_prev;
    logic                                r_out_valid;
    logic                                r_out_inside;
    logic                                r_out_hit;

    logic [CW-1:0]                       w_n;
    logic                                w_in_acc;
    logic                                w_query;
    logic                                w_load;
    logic                                w_shift;
    logic                                w_out_load;
    logic [ppc_pkg::IDX_W-1:0]           w_idx;
    ppc_pkg::t_vertex                    w_in_vtx;
    ppc_pkg::t_vertex                    w_vtx [MAX_VERTICES];
    ppc_pkg::t_edge_ctl                  w_ectl;
    ppc_pkg::t_edge_sts                  w_ests;

    // unpack the input beat
    assign w_idx      = i_s_axis_tdata[ppc_pkg::IDX_W-1:0];
    assign w_in_vtx.x = i_s_axis_tdata[19:4];
    assign w_in_vtx.y = i_s_axis_tdata[35:20];

    // count in use, clamped to the number of cells
    assign w_n = (32'(r_cnt) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : r_cnt;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_query         = w_in_acc && (i_s_axis_tuser == ppc_pkg::OP_QUERY);
    assign w_load          = w_in_acc && (i_s_axis_tuser == ppc_pkg::OP_LOAD);

    // The ring rotates n times per query. While the
    // previous-vertex register takes vertex 0 at the query beat, the ring rotates
    // once at that beat, then on every run step but the last, so the cells end
    // where they started. Edge pairs seen at the head: (v1,v0), (v2,v1), ..., (v0,v[n-1]).
    assign w_shift = (w_query && (w_n != '0)) || ((r_state == ST_RUN) && (r_step != '0));

    // ---------------- vertex ring ----------------
    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        ppc_pkg::t_cell_ctl w_cctl;
        ppc_pkg::t_vertex   w_next;

        assign w_cctl.wr    = w_load && (32'(w_idx) == 32'(k));
        assign w_cctl.shift = w_shift && (32'(k) < 32'(w_n));
        assign w_cctl.wrap  = ((32'(k) + 32'd1) == 32'(w_n));
        assign w_next       = w_vtx[(k + 1) % MAX_VERTICES];

        ppc_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_cctl),
            .i_wr_vtx (w_in_vtx),
            .i_next   (w_next),
            .i_first  (w_vtx[0]),
            .o_vtx    (w_vtx[k])
        );
    end

    // ---------------- edge test ----------------
    assign w_ectl.clear = w_query;
    assign w_ectl.issue = (r_state == ST_RUN);

    ppc_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ectl),
        .i_head  (w_vtx[0]),
        .i_prev  (r_prev),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_sts   (w_ests)
    );

    // ---------------- sequencer ----------------
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_step  = w_n - CW'(1);
                    n_state = (w_n == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                n_step = r_step - CW'(1);
                if (r_step == '0) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_ests.busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cnt <= i_cfg_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_px   <= w_in_vtx.x;
            r_py   <= w_in_vtx.y;
            r_prev <= w_vtx[0];
        end else if (r_state == ST_RUN) begin
            r_prev <= w_vtx[0];
        end
        if (w_out_load) begin
            // a vertex hit forces outside
            r_out_inside <= w_ests.parity && !w_ests.hit;
            r_out_hit    <= w_ests.hit;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(ppc_pkg::OUT_DATA_W - 2){1'b0}}, r_out_hit, r_out_inside};

    // ---------------- checks ----------------
    `PPC_ASSERT_IMP(a_idle_pipe_empty, i_clk, i_rst_n, r_state == ST_IDLE, !w_ests.busy)
    `PPC_ASSERT_IMP(a_step_in_range, i_clk, i_rst_n, r_state == ST_RUN, r_step < w_n)
    `PPC_ASSERT_IMP(a_hit_is_outside, i_clk, i_rst_n, r_out_valid && r_out_hit, !r_out_inside)
    `PPC_ASSERT_NXT(a_query_starts, i_clk, i_rst_n, w_query && (w_n != '0), r_state == ST_RUN)

endmodule

// File: bench/testbench.sv
// Self-checking bench for the polygon point containment unit: vertex loads, queries, count writes.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXV        = ppc_pkg::MAX_VERTICES_DEF;
    localparam int RANDOM_CMDS = 1950;      // stop building random beats past this
    localparam int SETTLE      = 40;        // longer than one query on the largest ring takes
    localparam int CYCLE_LIMIT = 600000;    // cycles before the run is declared hung
    localparam int PRINT_CAP   = 40;        // mismatch lines shown, all are counted

    // one input beat as the stimulus builder sees it
    typedef struct {
        logic                               opcode;
        logic [ppc_pkg::IDX_W-1:0]          slot;
        logic signed [ppc_pkg::COORD_W-1:0] x;
        logic signed [ppc_pkg::COORD_W-1:0] y;
    } t_point_cmd;

    // expected answer of one query, stamped with the cycle it was accepted
    typedef struct {
        logic                               in_poly;
        logic                               on_vertex;
        logic signed [ppc_pkg::COORD_W-1:0] qx;
        logic signed [ppc_pkg::COORD_W-1:0] qy;
        int unsigned                        stamp;
    } t_verdict;

    logic                            i_clk;
    logic                            i_rst_n         = 1'b0;
    logic                            i_cfg_valid     = 1'b0;
    logic [ppc_pkg::CNT_W-1:0]       i_cfg_data      = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic [ppc_pkg::IN_DATA_W-1:0]   i_s_axis_tdata  = '0;   // [3:0] vertex_index,
                                                             // [19:4] point_x,
                                                             // [35:20] point_y, rest 0
    logic                            i_s_axis_tuser  = 1'b0; // [0] opcode
    logic                            i_m_axis_tready = 1'b0;
    logic                            o_cfg_ready;
    logic                            o_s_axis_tready;
    logic                            o_m_axis_tvalid;
    logic [ppc_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata;         // [0] inside_res,
                                                             // [1] on_vertex, rest 0

    polygon_point_containment_unit #(
        .MAX_VERTICES(MAXV)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: vertex ring and count, updated on accepted beats
    // ------------------------------------------------------------------
    ppc_pkg::t_vertex          poly_ring [MAXV];
    logic [ppc_pkg::CNT_W-1:0] poly_count = '0;     // reset value of the count register

    t_point_cmd point_cmds[$];             // beats waiting for the driver
    t_verdict   verdicts_due[$];           // query answers not yet seen

    int unsigned cycles       = 0;
    int          cmds_queued  = 0;
    int          cmds_taken   = 0;
    int          mismatches   = 0;
    int          n_checked    = 0;
    int          n_inside     = 0;
    int          n_hits       = 0;
    int          n_loads      = 0;
    int          n_cfg        = 0;

    // stimulus-side copy of the vertices, used to aim queries
    int gen_x [MAXV];
    int gen_y [MAXV];
    int box_x0, box_y0, box_span;
    bit grid_mode;

    // Crossing-number test against the shadow ring. Edge i runs to i-1,
    // slot 0 closes to the last slot in use. No division: the side test is a
    // cross-multiplied compare whose sense flips with the sign of the y span.
    function automatic t_verdict classify_point(
            input logic signed [ppc_pkg::COORD_W-1:0] qx,
            input logic signed [ppc_pkg::COORD_W-1:0] qy);
        t_verdict                           v;
        int                                 n;
        int                                 j;
        logic signed [ppc_pkg::COORD_W-1:0] xi, yi, xj, yj;
        longint                             dy, lhs, rhs;
        bit                                 parity;
        bit                                 hit;
        bit                                 right_side;
        parity = 1'b0;
        hit    = 1'b0;
        n = (poly_count > MAXV) ? MAXV : int'(poly_count);
        for (int i = 0; i < n; i++) begin
            j  = (i == 0) ? n - 1 : i - 1;
            xi = poly_ring[i].x;
            yi = poly_ring[i].y;
            xj = poly_ring[j].x;
            yj = poly_ring[j].y;
            if (qx == xi && qy == yi)
                hit = 1'b1;
            // straddle: exactly one end strictly above the query line
            if ((yi > qy) != (yj > qy)) begin
                dy  = longint'(yj) - longint'(yi);
                lhs = (longint'(qx) - longint'(xi)) * dy;
                rhs = (longint'(xj) - longint'(xi)) * (longint'(qy) - longint'(yi));
                right_side = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
                if (right_side)
                    parity = ~parity;
            end
        end
        v.in_poly   = parity & ~hit;       // a vertex hit always reads outside
        v.on_vertex = hit;
        v.qx        = qx;
        v.qy        = qy;
        v.stamp     = cycles;
        return v;
    endfunction

    // predictor side of an accepted input beat
    function automatic void absorb_cmd(input t_point_cmd c);
        if (c.opcode == ppc_pkg::OP_LOAD) begin
            poly_ring[c.slot].x = c.x;
            poly_ring[c.slot].y = c.y;
            n_loads++;
        end else begin
            verdicts_due.push_back(classify_point(c.x, c.y));
        end
        cmds_taken++;
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout: %0d beats of %0d taken, %0d answers outstanding",
                     cmds_taken, cmds_queued, verdicts_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input driver: bursts of random length, random gaps, long clean runs
    // ------------------------------------------------------------------
    t_point_cmd cur_cmd;
    int         burst_left = 0;
    int         gap_left   = 0;

    always @(posedge i_clk) begin
        logic presenting;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            presenting = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                absorb_cmd(cur_cmd);
                presenting = 1'b0;
            end
            if (!presenting) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (point_cmds.size() > 0) begin
                    cur_cmd    = point_cmds.pop_front();
                    presenting = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(100, 300);   // stretch with no idling
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = $urandom_range(1, 8);
                    end
                end
            end
            // single update per edge: valid stays high across back-to-back beats
            i_s_axis_tvalid <= presenting;
            i_s_axis_tdata  <= {4'b0, cur_cmd.y, cur_cmd.x, cur_cmd.slot};
            i_s_axis_tuser  <= cur_cmd.opcode;
        end
    end

    // ------------------------------------------------------------------
    // Result side: tready follows one of a few stall patterns
    // ------------------------------------------------------------------
    int          stall_mode = 0;
    int          stall_left = 0;
    int          stall_pos  = 0;
    logic [15:0] stall_word = '1;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b1;
            stall_left = 0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(50, 300);
                stall_word = 16'($urandom) | 16'h0001;   // never a full stall
            end else begin
                stall_left--;
            end
            stall_pos = (stall_pos + 1) % 16;
            case (stall_mode)
                0:       i_m_axis_tready <= 1'b1;
                1:       i_m_axis_tready <= ($urandom_range(0, 2) != 0);
                default: i_m_axis_tready <= stall_word[stall_pos];
            endcase
        end
    end

    // Answers pushed at this same edge are not yet due: the stamp keeps the
    // check independent of which clocked block runs first.
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (verdicts_due.size() == 0 || verdicts_due[0].stamp == cycles) begin
                flag_mismatch($sformatf("result beat 0x%0h with no query waiting",
                                        o_m_axis_tdata));
            end else begin
                want = verdicts_due.pop_front();
                n_checked++;
                if (want.in_poly)
                    n_inside++;
                if (want.on_vertex)
                    n_hits++;
                if (o_m_axis_tdata[0] !== want.in_poly)
                    flag_mismatch($sformatf("inside_res %b, want %b for (%0d,%0d)",
                                            o_m_axis_tdata[0], want.in_poly,
                                            want.qx, want.qy));
                if (o_m_axis_tdata[1] !== want.on_vertex)
                    flag_mismatch($sformatf("on_vertex %b, want %b for (%0d,%0d)",
                                            o_m_axis_tdata[1], want.on_vertex,
                                            want.qx, want.qy));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_cmd(input logic opcode, input int slot, input int x, input int y);
        t_point_cmd c;
        c.opcode = opcode;
        c.slot   = slot[ppc_pkg::IDX_W-1:0];
        c.x      = x[ppc_pkg::COORD_W-1:0];
        c.y      = y[ppc_pkg::COORD_W-1:0];
        if (opcode == ppc_pkg::OP_LOAD) begin
            gen_x[c.slot] = c.x;
            gen_y[c.slot] = c.y;
        end
        point_cmds.push_back(c);
        cmds_queued++;
    endtask

    // sender holds off until every queued beat is taken and answered
    task automatic wait_for_answers();
        while (cmds_taken != cmds_queued || verdicts_due.size() != 0)
            @(posedge i_clk);
    endtask

    // count writes only with the block idle; loads leave no answer to wait
    // for, so give the ring time to finish its last pass as well
    task automatic set_vertex_count(input int value);
        wait_for_answers();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value[ppc_pkg::CNT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        poly_count = value[ppc_pkg::CNT_W-1:0];
        n_cfg++;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int box_coord(input int lo);
        if (grid_mode)
            return lo + int'($urandom_range(0, 4)) * (box_span / 4);
        return lo + int'($urandom_range(0, box_span));
    endfunction

    localparam int MIN_C = -32768;
    localparam int MAX_C = 32767;

    initial begin
        int forced_counts [7];
        int spans [4];
        int phase;
        int cnt;
        int nn;
        int rot;
        int n_query;
        int pick;
        int i;
        int j;
        int qx;
        int qy;
        int random_start;

        forced_counts = '{16, 31, 1, 2, 17, 0, 3};
        spans         = '{16, 256, 4096, 65535};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // empty polygon straight out of reset
        queue_cmd(ppc_pkg::OP_QUERY, 0, MIN_C, MAX_C);
        queue_cmd(ppc_pkg::OP_QUERY, 15, 0, 0);
        // full-range square, plus the top slot
        queue_cmd(ppc_pkg::OP_LOAD, 0, MIN_C, MIN_C);
        queue_cmd(ppc_pkg::OP_LOAD, 1, MAX_C, MIN_C);
        queue_cmd(ppc_pkg::OP_LOAD, 2, MAX_C, MAX_C);
        queue_cmd(ppc_pkg::OP_LOAD, 3, MIN_C, MAX_C);
        queue_cmd(ppc_pkg::OP_LOAD, 15, MAX_C, MIN_C);
        set_vertex_count(4);
        queue_cmd(ppc_pkg::OP_QUERY, 0, 0, 0);           // center
        queue_cmd(ppc_pkg::OP_QUERY, 0, MIN_C, MIN_C);   // on a corner
        queue_cmd(ppc_pkg::OP_QUERY, 0, MAX_C, MAX_C);   // on the opposite corner
        queue_cmd(ppc_pkg::OP_QUERY, 0, MAX_C, 0);       // right side
        queue_cmd(ppc_pkg::OP_QUERY, 0, MIN_C, 0);       // left side
        queue_cmd(ppc_pkg::OP_QUERY, 0, 0, MIN_C);       // on a horizontal edge
        queue_cmd(ppc_pkg::OP_QUERY, 0, 0, MAX_C);       // on the other one
        queue_cmd(ppc_pkg::OP_QUERY, 0, -1, -1);
        // triangle, then two- and one-vertex degenerate rings
        set_vertex_count(3);
        queue_cmd(ppc_pkg::OP_QUERY, 0, 16384, -16384);
        queue_cmd(ppc_pkg::OP_QUERY, 0, -16384, 16384);
        set_vertex_count(2);
        queue_cmd(ppc_pkg::OP_QUERY, 0, 0, 0);
        set_vertex_count(1);
        queue_cmd(ppc_pkg::OP_QUERY, 0, MIN_C, MIN_C);
        queue_cmd(ppc_pkg::OP_QUERY, 0, MIN_C, MIN_C + 1);

        // --- random phases: set a count, load the ring, then query it ---
        random_start = cmds_queued;
        phase = 0;
        while (cmds_queued - random_start < RANDOM_CMDS) begin
            if (phase < 7) begin
                cnt = forced_counts[phase];
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    cnt = $urandom_range(3, 8);
                else if (pick < 78)
                    cnt = $urandom_range(9, 16);
                else if (pick < 90)
                    cnt = $urandom_range(0, 2);
                else
                    cnt = $urandom_range(17, 31);   // clamps to a full ring
            end
            set_vertex_count(cnt);
            nn = (cnt > MAXV) ? MAXV : cnt;

            box_span  = spans[$urandom_range(0, 3)];
            box_x0    = MIN_C + int'($urandom_range(0, 65535 - box_span));
            box_y0    = MIN_C + int'($urandom_range(0, 65535 - box_span));
            grid_mode = ($urandom_range(0, 4) == 0);   // repeats, flat edges

            // every slot in use is written before the first query
            rot = (nn > 0) ? $urandom_range(0, nn - 1) : 0;
            for (int s = 0; s < nn; s++)
                queue_cmd(ppc_pkg::OP_LOAD, (s + rot) % nn, box_coord(box_x0),
                          box_coord(box_y0));
            if (nn < MAXV && $urandom_range(0, 2) == 0)
                queue_cmd(ppc_pkg::OP_LOAD, $urandom_range(nn, MAXV - 1),
                          int'($urandom_range(0, 65535)) + MIN_C,
                          int'($urandom_range(0, 65535)) + MIN_C);

            n_query = $urandom_range(12, 40);
            for (int k = 0; k < n_query; k++) begin
                if (k == n_query / 2 && phase % 4 == 1)
                    wait_for_answers();
                pick = $urandom_range(0, 99);
                i = (nn > 0) ? $urandom_range(0, nn - 1) : 0;
                j = (i == 0) ? nn - 1 : i - 1;
                if (nn > 0 && pick < 8) begin
                    // move a vertex in use mid-stream
                    queue_cmd(ppc_pkg::OP_LOAD, i, box_coord(box_x0), box_coord(box_y0));
                end else begin
                    if (nn > 0 && pick < 22) begin
                        qx = gen_x[i];
                        qy = gen_y[i];
                    end else if (nn > 0 && pick < 37) begin
                        qx = box_coord(box_x0);   // on a vertex's scan line
                        qy = gen_y[i];
                    end else if (nn > 0 && pick < 47) begin
                        qx = (gen_x[i] + gen_x[j]) >>> 1;
                        qy = (gen_y[i] + gen_y[j]) >>> 1;
                    end else if (pick < 57) begin
                        qx = int'($urandom_range(0, 65535)) + MIN_C;
                        qy = int'($urandom_range(0, 65535)) + MIN_C;
                    end else begin
                        qx = box_coord(box_x0);
                        qy = box_coord(box_y0);
                    end
                    queue_cmd(ppc_pkg::OP_QUERY, $urandom_range(0, MAXV - 1), qx, qy);
                end
            end
            phase++;
        end

        wait_for_answers();
        repeat (SETTLE) @(posedge i_clk);
        if (verdicts_due.size() != 0)
            flag_mismatch($sformatf("%0d answers never arrived", verdicts_due.size()));

        $display("run: %0d phases, %0d vertex loads, %0d count writes",
                 phase, n_loads, n_cfg);
        $display("run: %0d query answers checked, %0d inside, %0d on a vertex, %0d mismatches",
                 n_checked, n_inside, n_hits, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
